// ===== rtl/histogram_equalizer_core_defines.svh =====
// ---------------------------------------------------------------------------
// Histogram equalizer assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define HEQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histeq: check failed");

// next-cycle implication
`define HEQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histeq: check failed");

`else

`define HEQ_ASSERT_IMP(label, ante, cons)
`define HEQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/histeq_pkg.sv =====
// ---------------------------------------------------------------------------
// histeq_pkg
// Shared constants, operation codes and control structs of the equalizer.
// ---------------------------------------------------------------------------
package histeq_pkg;

    localparam int LOG2_PIXELS = 16;
    localparam int LEVELS      = 256;
    localparam int LVL_W       = 8;
    localparam int BIN_W       = LOG2_PIXELS + 1;
    localparam int PROD_W      = BIN_W + 8;

    localparam logic [BIN_W-1:0]  PIX_TOTAL = BIN_W'(1) << LOG2_PIXELS;
    localparam logic [PROD_W-1:0] HALF      = PROD_W'(1) << (LOG2_PIXELS - 1);

    typedef logic [1:0] op_t;
    localparam op_t OP_CNT = 2'd0;
    localparam op_t OP_MAP = 2'd1;
    localparam op_t OP_SUM = 2'd2;

    // memory access issued to the bin store
    typedef struct packed {
        logic             vld;
        op_t              op;
        logic [LVL_W-1:0] addr;
        logic             clr;   // drop all bins before this beat
    } iss_t;

    // update stage status back to control
    typedef struct packed {
        logic s1_vld;
        logic s1_map;
        logic sum_done;
    } upd_stat_t;

    // control status
    typedef struct packed {
        logic sum_busy;
        logic sums_ready;
    } ctrl_stat_t;

endpackage

// ===== rtl/histeq_ram.sv =====
// ---------------------------------------------------------------------------
// histeq_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module histeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/histeq_ctrl.sv =====
// ---------------------------------------------------------------------------
// histeq_ctrl
// Input acceptance, mode flags and the sequencer of the prefix-sum pass.
// ---------------------------------------------------------------------------
module histeq_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                req_type,
    input  logic [histeq_pkg::LVL_W-1:0]        pixel,
    output logic                                in_ready,
    input  logic                                stall,
    input  histeq_pkg::upd_stat_t               ust,
    output histeq_pkg::iss_t                    iss,
    output histeq_pkg::ctrl_stat_t              cst
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_SUM = 1'b1;

    logic                           state_reg, state_next;
    logic [histeq_pkg::LVL_W:0]     cnt_reg, cnt_next;
    logic                           map_mode_reg, map_mode_next;
    logic                           sums_ready_reg, sums_ready_next;
    logic                           need_sum;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        map_mode_next   = map_mode_reg;
        sums_ready_next = sums_ready_reg;
        need_sum        = 1'b0;
        in_ready        = 1'b0;
        iss             = '0;
        case (state_reg)
            ST_RUN:
            begin
                // first map beat after counting waits for the pass
                need_sum = in_valid && req_type && !sums_ready_reg;
                in_ready = !stall && !need_sum;
                if (need_sum && !ust.s1_vld)
                begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                end
                if (in_valid && in_ready)
                begin
                    iss.vld       = 1'b1;
                    iss.op        = req_type ? histeq_pkg::OP_MAP : histeq_pkg::OP_CNT;
                    iss.addr      = pixel;
                    iss.clr       = !req_type && map_mode_reg;
                    map_mode_next = req_type;
                    if (iss.clr)
                    begin
                        sums_ready_next = 1'b0;
                    end
                end
            end
            ST_SUM:
            begin
                if (!cnt_reg[histeq_pkg::LVL_W])
                begin
                    iss.vld  = 1'b1;
                    iss.op   = histeq_pkg::OP_SUM;
                    iss.addr = cnt_reg[histeq_pkg::LVL_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (ust.sum_done)
                begin
                    state_next      = ST_RUN;
                    sums_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            cnt_reg        <= '0;
            map_mode_reg   <= 1'b0;
            sums_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            map_mode_reg   <= map_mode_next;
            sums_ready_reg <= sums_ready_next;
        end
    end

    assign cst.sum_busy   = (state_reg == ST_SUM);
    assign cst.sums_ready = sums_ready_reg;

endmodule

// ===== rtl/histeq_upd.sv =====
// ---------------------------------------------------------------------------
// histeq_upd
// Bin store with valid bits, read-modify-write stage with forwarding,
// running-sum accumulator and the mapping arithmetic.
// ---------------------------------------------------------------------------
module histeq_upd (
    input  logic                            clk,
    input  logic                            rst_n,
    input  histeq_pkg::iss_t                iss,
    input  logic                            stall,
    output logic                            res_vld,
    output logic [7:0]                      res_data,
    output histeq_pkg::upd_stat_t           ust
);

    logic [histeq_pkg::LEVELS-1:0]   vbits_reg, vbits_next;
    logic                            s1_vld_reg;
    histeq_pkg::op_t                 s1_op_reg;
    logic [histeq_pkg::LVL_W-1:0]    s1_addr_reg;
    logic                            s1_vbit_reg;
    logic                            lw_vld_reg;
    logic [histeq_pkg::LVL_W-1:0]    lw_addr_reg;
    logic [histeq_pkg::BIN_W-1:0]    lw_data_reg;
    logic [histeq_pkg::BIN_W-1:0]    run_reg;

    logic [histeq_pkg::BIN_W-1:0]    rd_data;
    logic [histeq_pkg::BIN_W-1:0]    cur;
    logic [histeq_pkg::BIN_W-1:0]    run_base;
    logic [histeq_pkg::BIN_W:0]      run_sum;
    logic [histeq_pkg::BIN_W-1:0]    run_sat;
    logic [histeq_pkg::BIN_W-1:0]    cnt_inc;
    logic [histeq_pkg::PROD_W-1:0]   prod;
    logic                            wr_en;
    logic [histeq_pkg::BIN_W-1:0]    wr_data;

    histeq_ram #(
        .WIDTH (histeq_pkg::BIN_W),
        .DEPTH (histeq_pkg::LEVELS)
    ) u_bins (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (iss.vld),
        .raddr (iss.addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        // write landing on the read edge is not seen by the RAM read
        if (lw_vld_reg && (lw_addr_reg == s1_addr_reg))
        begin
            cur = lw_data_reg;
        end
        else if (s1_vbit_reg)
        begin
            cur = rd_data;
        end
        else
        begin
            cur = '0;
        end

        cnt_inc  = (cur == histeq_pkg::PIX_TOTAL) ? cur : cur + 1'b1;

        run_base = (s1_addr_reg == '0) ? '0 : run_reg;
        run_sum  = {1'b0, run_base} + {1'b0, cur};
        run_sat  = (run_sum > {1'b0, histeq_pkg::PIX_TOTAL}) ?
                   histeq_pkg::PIX_TOTAL : run_sum[histeq_pkg::BIN_W-1:0];

        // 255*cdf = 256*cdf - cdf, plus half for rounding
        prod = {cur, 8'd0} - {8'd0, cur} + histeq_pkg::HALF;

        wr_en   = 1'b0;
        wr_data = cnt_inc;
        case (s1_op_reg)
            histeq_pkg::OP_CNT:
            begin
                wr_en   = s1_vld_reg;
                wr_data = cnt_inc;
            end
            histeq_pkg::OP_SUM:
            begin
                wr_en   = s1_vld_reg;
                wr_data = run_sat;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        vbits_next = iss.clr ? '0 : vbits_reg;
        if (wr_en)
        begin
            vbits_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg  <= '0;
            s1_vld_reg <= 1'b0;
            lw_vld_reg <= 1'b0;
        end
        else if (!stall)
        begin
            vbits_reg  <= vbits_next;
            s1_vld_reg <= iss.vld;
            lw_vld_reg <= wr_en && !iss.clr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_op_reg   <= iss.op;
            s1_addr_reg <= iss.addr;
            s1_vbit_reg <= iss.clr ? 1'b0 : vbits_reg[iss.addr];
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= wr_data;
            if (s1_vld_reg && (s1_op_reg == histeq_pkg::OP_SUM))
            begin
                run_reg <= run_sat;
            end
        end
    end

    assign res_vld      = s1_vld_reg && (s1_op_reg == histeq_pkg::OP_MAP);
    assign res_data     = prod[histeq_pkg::LOG2_PIXELS +: 8];
    assign ust.s1_vld   = s1_vld_reg;
    assign ust.s1_map   = res_vld;
    assign ust.sum_done = s1_vld_reg && (s1_op_reg == histeq_pkg::OP_SUM) &&
                          (s1_addr_reg == {histeq_pkg::LVL_W{1'b1}});

endmodule

// ===== rtl/histogram_equalizer_core.sv =====
// ---------------------------------------------------------------------------
// histogram_equalizer_core
// 8-bit histogram equalizer over a frame streamed in twice: a count pass
// builds 256 bins, a map pass returns the rounded, scaled cumulative sum.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------
//   in      | in_valid / in_ready | req_type, pixel
//   out     | out_valid/out_ready | mapped_pixel
//
// Cycles: one beat per clock for count and map beats when not stalled; each
// beat is a read of the bin memory into the update stage, which modifies
// the bin and writes it back. The first map beat after a count pass waits
// for the last count write and for the prefix pass, which runs one level
// per cycle through the single bin memory read and write ports.
// Reset: valid-bit flops clear the bins at once; no clearing pass.
// Stalls: a map beat whose result meets a full output register holds the
// update stage and stops intake until the output beat is taken.
// ---------------------------------------------------------------------------
`include "histogram_equalizer_core_defines.svh"

module histogram_equalizer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [histeq_pkg::LVL_W-1:0]    pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      mapped_pixel
);

    histeq_pkg::iss_t           iss;
    histeq_pkg::upd_stat_t      ust;
    histeq_pkg::ctrl_stat_t     cst;
    logic                       stall;
    logic                       res_vld;
    logic [7:0]                 res_data;
    logic                       out_valid_reg;
    logic [7:0]                 mapped_reg;
    logic                       load;

    // map result blocked by an untaken output beat
    assign stall = ust.s1_map && out_valid_reg && !out_ready;
    assign load  = res_vld && !stall;

    histeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .pixel    (pixel),
        .in_ready (in_ready),
        .stall    (stall),
        .ust      (ust),
        .iss      (iss),
        .cst      (cst)
    );

    histeq_upd u_upd (
        .clk      (clk),
        .rst_n    (rst_n),
        .iss      (iss),
        .stall    (stall),
        .res_vld  (res_vld),
        .res_data (res_data),
        .ust      (ust)
    );

    // output register parts update stage from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mapped_reg <= res_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mapped_pixel = mapped_reg;

    // no intake while the prefix pass owns the memory
    `HEQ_ASSERT_IMP(a_no_intake_in_pass, in_valid && in_ready, !cst.sum_busy)
    // a count beat never produces a result
    `HEQ_ASSERT_NXT(a_count_silent, in_valid && in_ready && !req_type, !res_vld)
    // a map beat is only taken once sums are built
    `HEQ_ASSERT_IMP(a_map_after_sums, in_valid && in_ready && req_type, cst.sums_ready)

endmodule

// ===== sim/histogram_equalizer_core_tb.sv =====
// ---------------------------------------------------------------------------
// histogram_equalizer_core_tb
// Streams count and map beats into the equalizer with random gaps on both
// channels and two long output hold-offs. A local bin model predicts every
// mapped level, and the monitor checks each output beat in order.
// ---------------------------------------------------------------------------
module histogram_equalizer_core_tb;

    localparam int LOG2_PIXELS = histeq_pkg::LOG2_PIXELS;
    localparam int LEVELS      = histeq_pkg::LEVELS;
    localparam int LVL_W       = histeq_pkg::LVL_W;

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_MAP   = 1'b1;

    localparam longint unsigned FRAME_PIXELS = 64'd1 << LOG2_PIXELS;

    localparam int RESET_CYCLES  = 12;
    localparam int MAX_GAP       = 12;
    localparam int TAIL_BEATS    = 250;     // no idling once this few remain
    localparam int RANDOM_BEATS  = 1030;
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES  = 300;     // covers the prefix pass
    localparam int STALL_LIMIT   = 4000;    // cycles with no beat on either side

    typedef struct packed {
        logic             req;
        logic [LVL_W-1:0] lvl;
    } pix_beat_t;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [7:0]       level;
    } mapped_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             req_type  = REQ_COUNT;
    logic [LVL_W-1:0] pixel     = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       mapped_pixel;

    histogram_equalizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mapped_pixel (mapped_pixel)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Bin model: counts per level, turned in place into running sums on the
    // first map beat of a pass.
    // -----------------------------------------------------------------------
    longint unsigned bin_count [LEVELS];
    bit              in_map_pass = 1'b0;
    bit              sums_built  = 1'b0;

    pix_beat_t pending_beats [$];
    mapped_t   expected_levels [$];

    int fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    task automatic equalize_beat(input pix_beat_t b);
        longint unsigned run;
        longint unsigned scaled;
        mapped_t         m;
        if (b.req == REQ_COUNT)
        begin
            // count after map: fresh frame, drop all bins first
            if (in_map_pass)
            begin
                foreach (bin_count[l])
                    bin_count[l] = 0;
                in_map_pass = 1'b0;
                sums_built  = 1'b0;
            end
            if (bin_count[b.lvl] < FRAME_PIXELS)
                bin_count[b.lvl]++;
        end
        else
        begin
            in_map_pass = 1'b1;
            if (!sums_built)
            begin
                run = 0;
                for (int l = 0; l < LEVELS; l++)
                begin
                    run += bin_count[l];
                    if (run > FRAME_PIXELS)
                        run = FRAME_PIXELS;
                    bin_count[l] = run;
                end
                sums_built = 1'b1;
            end
            scaled = (255 * bin_count[b.lvl] + (FRAME_PIXELS >> 1)) >> LOG2_PIXELS;
            if (scaled > 255)
                scaled = 255;
            m.lvl   = b.lvl;
            m.level = scaled[7:0];
            expected_levels.push_back(m);
        end
    endtask

    task automatic add_beat(input logic req, input logic [LVL_W-1:0] lvl);
        pix_beat_t b;
        b.req = req;
        b.lvl = lvl;
        pending_beats.push_back(b);
    endtask

    // idle mode: often none at all, sometimes light or heavy
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 10;
            3:       return 30;
            default: return 60;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Driver: offers the pending beats in order; gaps only between beats, so
    // a beat once offered stays put until taken.
    // -----------------------------------------------------------------------
    pix_beat_t on_wire;
    int        gap_left   = 0;
    int        tx_gap_pct = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                equalize_beat(on_wire);
            if ($urandom_range(0, 199) == 0)
                tx_gap_pct = pick_idle_pct();
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > TAIL_BEATS &&
                         $urandom_range(0, 99) < tx_gap_pct)
                begin
                    gap_left = $urandom_range(1, MAX_GAP) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    on_wire = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    req_type <= on_wire.req;
                    pixel    <= on_wire.lvl;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: checks each output beat against the oldest prediction and
    // throttles out_ready. Two long hold-offs let the block back up into
    // its input while the driver keeps offering.
    // -----------------------------------------------------------------------
    mapped_t want;
    int      results_seen = 0;
    int      stall_left   = 0;
    int      hold_left    = 0;
    int      hold_idx     = 0;
    int      hold_marks [2] = '{150, 350};
    int      rx_stall_pct = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_levels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output beat, mapped_pixel %0d",
                                              mapped_pixel));
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (mapped_pixel !== want.level)
                        report_mismatch($sformatf(
                            "mapped_pixel for level %0d: got %0d, want %0d",
                            want.lvl, mapped_pixel, want.level));
                end
            end
            if ($urandom_range(0, 199) == 0)
                rx_stall_pct = pick_idle_pct();
            if (hold_idx < 2 && hold_left == 0 && pending_beats.size() > TAIL_BEATS &&
                results_seen >= hold_marks[hold_idx])
            begin
                hold_left = HOLD_CYCLES;
                hold_idx++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (pending_beats.size() > TAIL_BEATS &&
                     $urandom_range(0, 99) < rx_stall_pct)
            begin
                stall_left = $urandom_range(1, MAX_GAP) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run.
    // -----------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    int rand_beats;
    int n_cnt;
    int n_map;
    int lo;
    int hi;

    initial
    begin
        foreach (bin_count[l])
            bin_count[l] = 0;

        // map with nothing counted: all-zero sums
        add_beat(REQ_MAP, 8'd0);
        add_beat(REQ_MAP, 8'd255);
        // small count pass over the extremes, the midpoint pair and alternating bit patterns
        add_beat(REQ_COUNT, 8'd0);
        add_beat(REQ_COUNT, 8'd255);
        add_beat(REQ_COUNT, 8'h55);
        add_beat(REQ_COUNT, 8'hAA);
        add_beat(REQ_COUNT, 8'h80);
        add_beat(REQ_COUNT, 8'h7F);
        add_beat(REQ_COUNT, 8'd255);
        add_beat(REQ_MAP, 8'd0);
        add_beat(REQ_MAP, 8'd255);
        add_beat(REQ_MAP, 8'h7F);
        add_beat(REQ_MAP, 8'hAA);
        add_beat(REQ_MAP, 8'h55);
        // count after map clears the bins
        add_beat(REQ_COUNT, 8'd1);
        add_beat(REQ_MAP, 8'd255);
        add_beat(REQ_MAP, 8'd0);

        // mid-size frame: spread counts with one heavy bin, then a map
        // over every level
        for (int i = 0; i < 200; i++)
            add_beat(REQ_COUNT, LVL_W'($urandom_range(0, 255)));
        for (int i = 0; i < 40; i++)
            add_beat(REQ_COUNT, 8'd200);
        for (int l = 0; l < LEVELS; l++)
            add_beat(REQ_MAP, LVL_W'(l));

        // random frames: count pass over a random window, then a map pass;
        // the odd burst of noise with mixed beat types
        rand_beats = 0;
        while (rand_beats < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n_cnt = $urandom_range(1, 120);
                lo    = $urandom_range(0, 255);
                hi    = $urandom_range(lo, 255);
                for (int i = 0; i < n_cnt; i++)
                    add_beat(REQ_COUNT, LVL_W'($urandom_range(lo, hi)));
                n_map = $urandom_range(1, 40);
                for (int i = 0; i < n_map; i++)
                    add_beat(REQ_MAP, LVL_W'($urandom_range(0, 255)));
                rand_beats += n_cnt + n_map;
            end
            else
            begin
                n_cnt = $urandom_range(1, 20);
                for (int i = 0; i < n_cnt; i++)
                    add_beat(1'($urandom_range(0, 1)), LVL_W'($urandom_range(0, 255)));
                rand_beats += n_cnt;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_levels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
